@@ rtl/core/nnf_pkg.sv @@
// nnf_pkg: shared types and default sizes for the node neighbourhood feature core
// used by nnf_ctrl, nnf_datapath and node_neighbourhood_features_core
package nnf_pkg;

  localparam int WEIGHT_BITS_DEF = 20;
  localparam int DEGREE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  typedef enum logic [0:0] {
    ST_COLLECT = 1'b0,
    ST_DIVIDE  = 1'b1
  } nnf_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // input beat accepted
    logic start;  // accepted beat finishes a node: snapshot and start divider
    logic step;   // one divider iteration
    logic load;   // move finished features into the output register
  } nnf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;    // the beat on the input would finish a node
    logic div_done;  // divider has produced all quotient bits
  } nnf_sts_t;

endpackage

@@ rtl/core/nnf_datapath.sv @@
// nnf_datapath: per-node accumulators, feature snapshot, restoring divider and output register
// depends on nnf_pkg; driven by nnf_ctrl through nnf_cmd_t / nnf_sts_t
module nnf_datapath import nnf_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  nnf_cmd_t                                 cmd,
  output nnf_sts_t                                 sts,
  input  logic                                     mode,
  input  logic [WEIGHT_BITS-1:0]                   item_weight,
  input  logic [DEGREE_BITS-1:0]                   item_degree,
  output logic [WEIGHT_BITS-1:0]                   own_weight,
  output logic signed [WEIGHT_BITS+DEGREE_BITS:0]  weight_difference,
  output logic [WEIGHT_BITS-1:0]                   min_nbr_weight,
  output logic [WEIGHT_BITS-1:0]                   max_nbr_weight,
  output logic [DEGREE_BITS-1:0]                   own_degree,
  output logic [DEGREE_BITS+FRAC_BITS-1:0]         avg_nbr_degree_q8,
  output logic [DEGREE_BITS-1:0]                   min_nbr_degree,
  output logic [DEGREE_BITS-1:0]                   max_nbr_degree
);

  localparam int WSUM_BITS = WEIGHT_BITS + DEGREE_BITS;
  localparam int DSUM_BITS = 2 * DEGREE_BITS;
  localparam int DIFF_BITS = WEIGHT_BITS + DEGREE_BITS + 1;
  localparam int AVG_BITS  = DEGREE_BITS + FRAC_BITS;
  localparam int NUM_BITS  = DSUM_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

  // node state
  logic                   node_open, node_open_next;
  logic [WEIGHT_BITS-1:0] held_weight, held_weight_next;
  logic [DEGREE_BITS-1:0] held_degree, held_degree_next;
  logic [DEGREE_BITS-1:0] neighbours_seen, neighbours_seen_next;
  logic [WSUM_BITS-1:0]   weight_sum, weight_sum_next;
  logic [DSUM_BITS-1:0]   degree_sum, degree_sum_next;
  logic [WEIGHT_BITS-1:0] low_weight, low_weight_next;
  logic [WEIGHT_BITS-1:0] high_weight, high_weight_next;
  logic [DEGREE_BITS-1:0] low_degree, low_degree_next;
  logic [DEGREE_BITS-1:0] high_degree, high_degree_next;
  logic                   finish;

  // snapshot of a finished node
  logic [WEIGHT_BITS-1:0] snap_weight;
  logic [DIFF_BITS-1:0]   snap_diff;
  logic [WEIGHT_BITS-1:0] snap_low_weight;
  logic [WEIGHT_BITS-1:0] snap_high_weight;
  logic [DEGREE_BITS-1:0] snap_degree;
  logic [DEGREE_BITS-1:0] snap_low_degree;
  logic [DEGREE_BITS-1:0] snap_high_degree;

  // divider
  logic [NUM_BITS-1:0]    div_work;
  logic [DEGREE_BITS-1:0] div_rem;
  logic [CNT_BITS-1:0]    div_cnt;
  logic [DEGREE_BITS:0]   rem_shift;
  logic [DEGREE_BITS:0]   rem_sub;
  logic                   rem_ge;

  always_comb begin
    node_open_next       = node_open;
    held_weight_next     = held_weight;
    held_degree_next     = held_degree;
    neighbours_seen_next = neighbours_seen;
    weight_sum_next      = weight_sum;
    degree_sum_next      = degree_sum;
    low_weight_next      = low_weight;
    high_weight_next     = high_weight;
    low_degree_next      = low_degree;
    high_degree_next     = high_degree;
    finish               = 1'b0;
    if (!mode) begin
      held_weight_next     = item_weight;
      held_degree_next     = item_degree;
      neighbours_seen_next = '0;
      weight_sum_next      = '0;
      degree_sum_next      = '0;
      low_weight_next      = '0;
      high_weight_next     = '0;
      low_degree_next      = '0;
      high_degree_next     = '0;
      finish               = (item_degree == '0);
      node_open_next       = !finish;
    end else if (node_open) begin
      neighbours_seen_next = neighbours_seen + DEGREE_BITS'(1);
      weight_sum_next      = weight_sum + WSUM_BITS'(item_weight);
      degree_sum_next      = degree_sum + DSUM_BITS'(item_degree);
      // a zero minimum means unset and is always replaced
      if (item_weight < low_weight || low_weight == '0) begin
        low_weight_next = item_weight;
      end
      if (item_weight > high_weight) begin
        high_weight_next = item_weight;
      end
      if (item_degree < low_degree || low_degree == '0) begin
        low_degree_next = item_degree;
      end
      if (item_degree > high_degree) begin
        high_degree_next = item_degree;
      end
      finish         = (neighbours_seen_next == held_degree);
      node_open_next = !finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_open <= 1'b0;
    end else if (cmd.take) begin
      node_open <= node_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held_weight     <= held_weight_next;
      held_degree     <= held_degree_next;
      neighbours_seen <= neighbours_seen_next;
      weight_sum      <= weight_sum_next;
      degree_sum      <= degree_sum_next;
      low_weight      <= low_weight_next;
      high_weight     <= high_weight_next;
      low_degree      <= low_degree_next;
      high_degree     <= high_degree_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      snap_weight      <= held_weight_next;
      snap_diff        <= DIFF_BITS'(held_weight_next) - DIFF_BITS'(weight_sum_next);
      snap_low_weight  <= low_weight_next;
      snap_high_weight <= high_weight_next;
      snap_degree      <= held_degree_next;
      snap_low_degree  <= low_degree_next;
      snap_high_degree <= high_degree_next;
    end
  end

  // restoring division, one quotient bit per cycle; quotient bits shift into div_work
  assign rem_shift = {div_rem, div_work[NUM_BITS-1]};
  assign rem_sub   = rem_shift - {1'b0, snap_degree};
  assign rem_ge    = (rem_shift >= {1'b0, snap_degree});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_work <= NUM_BITS'(degree_sum_next) << FRAC_BITS;
      div_rem  <= '0;
    end else if (cmd.step) begin
      div_work <= {div_work[NUM_BITS-2:0], rem_ge};
      div_rem  <= rem_ge ? rem_sub[DEGREE_BITS-1:0] : rem_shift[DEGREE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start) begin
      div_cnt <= CNT_BITS'(NUM_BITS);
    end else if (cmd.step) begin
      div_cnt <= div_cnt - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      own_weight        <= snap_weight;
      weight_difference <= snap_diff;
      min_nbr_weight    <= snap_low_weight;
      max_nbr_weight    <= snap_high_weight;
      own_degree        <= snap_degree;
      // degree zero has no neighbours: average is zero
      avg_nbr_degree_q8 <= (snap_degree == '0) ? '0 : div_work[AVG_BITS-1:0];
      min_nbr_degree    <= snap_low_degree;
      max_nbr_degree    <= snap_high_degree;
    end
  end

  assign sts.finish   = finish;
  assign sts.div_done = (div_cnt == '0);

endmodule

@@ rtl/core/nnf_ctrl.sv @@
// nnf_ctrl: state machine sequencing collection, division and the output register
// depends on nnf_pkg; commands nnf_datapath
module nnf_ctrl import nnf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output nnf_cmd_t cmd,
  input  nnf_sts_t sts
);

  nnf_state_t state, state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (s_tvalid && sts.finish) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done && out_free) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_COLLECT: begin
        s_tready  = 1'b1;
        cmd.take  = s_tvalid;
        cmd.start = s_tvalid && sts.finish;
      end
      ST_DIVIDE: begin
        cmd.step = !sts.div_done;
        cmd.load = sts.div_done && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_load_after_divide : assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.div_done)
    else $error("output loaded before divider finished");

  a_load_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a beat waits");

  a_valid_from_load : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load))
    else $error("output valid rose without a load");

  a_start_runs_divider : assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (!sts.div_done && state == ST_DIVIDE))
    else $error("divider not running after node finished");

endmodule

@@ rtl/core/node_neighbourhood_features_core.sv @@
// Per-node neighbourhood feature extractor. A header beat (tuser = 0) opens a node with its own
// weight and degree; each following neighbour beat (tuser = 1) is accepted while collecting. After
// the degree-th neighbour, or right after a header of degree zero, the average neighbour degree
// is formed by a restoring divider that makes one quotient bit per cycle, so input is held off
// while it runs and until the result is loaded. A node with k neighbours costs k+1 input
// beats. The result sits in an output register, so the next node can be collected while it
// waits. Neighbour beats with no open node are dropped; a header while a node is open discards
// that node.
// depends on nnf_pkg, nnf_ctrl, nnf_datapath
module node_neighbourhood_features_core import nnf_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // item_weight, item_degree
  input  logic [((WEIGHT_BITS+DEGREE_BITS+7)/8)*8-1:0] s_tdata,
  // mode
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // own_weight, weight_difference, min_nbr_weight, max_nbr_weight, own_degree,
  // avg_nbr_degree_q8, min_nbr_degree, max_nbr_degree
  output logic [((4*WEIGHT_BITS+5*DEGREE_BITS+FRAC_BITS+1+7)/8)*8-1:0] m_tdata
);

  localparam int DIFF_BITS = WEIGHT_BITS + DEGREE_BITS + 1;
  localparam int AVG_BITS  = DEGREE_BITS + FRAC_BITS;
  localparam int OUT_BITS  = 4 * WEIGHT_BITS + 5 * DEGREE_BITS + FRAC_BITS + 1;

  nnf_cmd_t cmd;
  nnf_sts_t sts;

  logic [WEIGHT_BITS-1:0]        own_weight;
  logic signed [DIFF_BITS-1:0]   weight_difference;
  logic [WEIGHT_BITS-1:0]        min_nbr_weight;
  logic [WEIGHT_BITS-1:0]        max_nbr_weight;
  logic [DEGREE_BITS-1:0]        own_degree;
  logic [AVG_BITS-1:0]           avg_nbr_degree_q8;
  logic [DEGREE_BITS-1:0]        min_nbr_degree;
  logic [DEGREE_BITS-1:0]        max_nbr_degree;

  nnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  nnf_datapath #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .DEGREE_BITS (DEGREE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .mode              (s_tuser[0]),
    .item_weight       (s_tdata[WEIGHT_BITS-1:0]),
    .item_degree       (s_tdata[WEIGHT_BITS+DEGREE_BITS-1:WEIGHT_BITS]),
    .own_weight        (own_weight),
    .weight_difference (weight_difference),
    .min_nbr_weight    (min_nbr_weight),
    .max_nbr_weight    (max_nbr_weight),
    .own_degree        (own_degree),
    .avg_nbr_degree_q8 (avg_nbr_degree_q8),
    .min_nbr_degree    (min_nbr_degree),
    .max_nbr_degree    (max_nbr_degree)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_BITS-1:0] = {max_nbr_degree, min_nbr_degree, avg_nbr_degree_q8, own_degree,
                             max_nbr_weight, min_nbr_weight, weight_difference, own_weight};
  end

endmodule

@@ tb/node_neighbourhood_features_core_tb.sv @@
// Self-checking bench for node_neighbourhood_features_core: header and neighbour beats in,
// eight-feature result beats out, checked against an in-bench model of the node collector.
// depends on nnf_pkg and the core RTL
`timescale 1ns / 100ps

module node_neighbourhood_features_core_tb import nnf_pkg::*;;

  localparam int W = WEIGHT_BITS_DEF;
  localparam int D = DEGREE_BITS_DEF;
  localparam int F = FRAC_BITS_DEF;
  localparam int IN_BITS = ((W + D + 7) / 8) * 8;
  localparam int OUT_BITS = ((4 * W + 5 * D + F + 1 + 7) / 8) * 8;
  localparam int FEAT_BITS = 4 * W + 5 * D + F + 1;
  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_TAIL = 150;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_NBR    = 1'b1;

  typedef struct packed {
    logic         mode;
    logic [W-1:0] weight;
    logic [D-1:0] degree;
    logic         drain_first;  // hold this beat back until all results are out
  } node_item_t;

  // highest field first so the struct maps straight onto m_tdata
  typedef struct packed {
    logic [D-1:0]   max_nbr_degree;
    logic [D-1:0]   min_nbr_degree;
    logic [D+F-1:0] avg_nbr_degree_q8;
    logic [D-1:0]   own_degree;
    logic [W-1:0]   max_nbr_weight;
    logic [W-1:0]   min_nbr_weight;
    logic [W+D:0]   weight_difference;
    logic [W-1:0]   own_weight;
  } features_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;  // item_weight, item_degree
  logic [0:0] s_tuser = '0;          // mode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;      // own_weight .. max_nbr_degree

  node_neighbourhood_features_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  node_item_t pending_items[$];
  features_t  expected_features[$];
  node_item_t cur_item;

  // collector model state
  logic         node_live = 1'b0;
  logic [W-1:0] own_w = '0;
  logic [D-1:0] own_d = '0;
  logic [D-1:0] nbr_count = '0;
  logic [W+D-1:0] w_total = '0;
  logic [2*D-1:0] d_total = '0;
  logic [W-1:0] w_lo = '0, w_hi = '0;
  logic [D-1:0] d_lo = '0, d_hi = '0;

  int errors = 0;
  int results_seen = 0;
  int nodes_done = 0;
  int nodes_abandoned = 0;
  int strays_dropped = 0;
  int gap_left = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    errors++;
  endtask

  function automatic features_t node_features();
    features_t  f;
    logic [63:0] avg;
    avg = '0;
    if (own_d != '0) avg = ({32'b0, d_total} << F) / own_d;
    f.own_weight        = own_w;
    f.weight_difference = {{(D + 1){1'b0}}, own_w} - {1'b0, w_total};
    f.min_nbr_weight    = w_lo;
    f.max_nbr_weight    = w_hi;
    f.own_degree        = own_d;
    f.avg_nbr_degree_q8 = avg[D+F-1:0];
    f.min_nbr_degree    = d_lo;
    f.max_nbr_degree    = d_hi;
    return f;
  endfunction

  task automatic collect_beat(input node_item_t it);
    if (it.mode == MODE_HEADER) begin
      if (node_live) nodes_abandoned++;
      own_w = it.weight;
      own_d = it.degree;
      nbr_count = '0;
      w_total = '0;
      d_total = '0;
      w_lo = '0;
      w_hi = '0;
      d_lo = '0;
      d_hi = '0;
      node_live = (it.degree != '0);
      if (it.degree == '0) begin
        expected_features.push_back(node_features());
        nodes_done++;
      end
    end else if (!node_live) begin
      strays_dropped++;
    end else begin
      nbr_count = nbr_count + 1'b1;
      w_total = w_total + it.weight;
      d_total = d_total + it.degree;
      // zero in a minimum means nothing stored yet
      if (it.weight < w_lo || w_lo == '0) w_lo = it.weight;
      if (it.weight > w_hi) w_hi = it.weight;
      if (it.degree < d_lo || d_lo == '0) d_lo = it.degree;
      if (it.degree > d_hi) d_hi = it.degree;
      if (nbr_count == own_d) begin
        node_live = 1'b0;
        expected_features.push_back(node_features());
        nodes_done++;
      end
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) collect_beat(cur_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || expected_features.size() == 0)) begin
          if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 5);
            s_tvalid <= 1'b0;
          end else begin
            cur_item = pending_items.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_BITS - W - D){1'b0}}, cur_item.degree, cur_item.weight};
            s_tuser  <= cur_item.mode;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    features_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[FEAT_BITS-1:0];
        if (expected_features.size() == 0) begin
          report_mismatch("result beat with no node finished, own_weight",
                          64'(got.own_weight), 64'(0));
        end else begin
          want = expected_features.pop_front();
          if (got.own_weight !== want.own_weight)
            report_mismatch("own_weight", 64'(got.own_weight), 64'(want.own_weight));
          if (got.weight_difference !== want.weight_difference)
            report_mismatch("weight_difference", 64'(got.weight_difference),
                            64'(want.weight_difference));
          if (got.min_nbr_weight !== want.min_nbr_weight)
            report_mismatch("min_nbr_weight", 64'(got.min_nbr_weight),
                            64'(want.min_nbr_weight));
          if (got.max_nbr_weight !== want.max_nbr_weight)
            report_mismatch("max_nbr_weight", 64'(got.max_nbr_weight),
                            64'(want.max_nbr_weight));
          if (got.own_degree !== want.own_degree)
            report_mismatch("own_degree", 64'(got.own_degree), 64'(want.own_degree));
          if (got.avg_nbr_degree_q8 !== want.avg_nbr_degree_q8)
            report_mismatch("avg_nbr_degree_q8", 64'(got.avg_nbr_degree_q8),
                            64'(want.avg_nbr_degree_q8));
          if (got.min_nbr_degree !== want.min_nbr_degree)
            report_mismatch("min_nbr_degree", 64'(got.min_nbr_degree),
                            64'(want.min_nbr_degree));
          if (got.max_nbr_degree !== want.max_nbr_degree)
            report_mismatch("max_nbr_degree", 64'(got.max_nbr_degree),
                            64'(want.max_nbr_degree));
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_item(input logic mode, input logic [W-1:0] weight,
                          input logic [D-1:0] degree, input logic drain_first = 1'b0);
    node_item_t it;
    it.mode = mode;
    it.weight = weight;
    it.degree = degree;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  function automatic logic [W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return W'($urandom_range(0, (1 << W) - 1));
    endcase
  endfunction

  function automatic logic [D-1:0] pick_degree();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return D'($urandom_range(1, 16));
      default: return D'($urandom_range(0, (1 << D) - 1));
    endcase
  endfunction

  initial begin
    int kind, deg, k;
    logic drained_once;
    drained_once = 1'b0;

    // degree zero header finishes at once, then a stray neighbour
    add_item(MODE_HEADER, '1, '0);
    add_item(MODE_NBR, 20'h12345, 16'd7);
    // single neighbour at full scale drives the difference negative
    add_item(MODE_HEADER, '0, 16'd1);
    add_item(MODE_NBR, '1, '1, 1'b1);
    // zero neighbour values get replaced in the minimums
    add_item(MODE_HEADER, 20'd100, 16'd3);
    add_item(MODE_NBR, '0, '0);
    add_item(MODE_NBR, 20'd5, 16'd9);
    add_item(MODE_NBR, 20'd2, 16'd4);
    // open node dropped by a new header
    add_item(MODE_HEADER, 20'd77, 16'd2);
    add_item(MODE_NBR, 20'd3, 16'd3);
    add_item(MODE_HEADER, '1, 16'd2);
    add_item(MODE_NBR, '1, '1);
    add_item(MODE_NBR, 20'd1, 16'd1);
    add_item(MODE_NBR, 20'd9, 16'd9);
    // full-scale neighbours for large sums and the largest average
    add_item(MODE_HEADER, 20'h5a5a5, 16'd3);
    add_item(MODE_NBR, '1, '1);
    add_item(MODE_NBR, '1, '1);
    add_item(MODE_NBR, '1, '1);
    // largest degree header, abandoned, then a zero node
    add_item(MODE_HEADER, 20'd1, '1);
    add_item(MODE_NBR, 20'd6, 16'd2);
    add_item(MODE_HEADER, '0, '0);

    while (pending_items.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        deg = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        add_item(MODE_HEADER, pick_weight(), D'(deg),
                 !drained_once && pending_items.size() > RANDOM_ITEMS / 2);
        if (pending_items.size() > RANDOM_ITEMS / 2) drained_once = 1'b1;
        for (int i = 0; i < deg; i++) add_item(MODE_NBR, pick_weight(), pick_degree());
      end else if (kind < 90) begin
        // header given fewer neighbour beats than its degree (unless the degree is zero)
        deg = int'(pick_degree());
        k = (deg > 1) ? $urandom_range(0, (deg - 1 < 5) ? deg - 1 : 5) : 0;
        add_item(MODE_HEADER, pick_weight(), D'(deg));
        for (int i = 0; i < k; i++) add_item(MODE_NBR, pick_weight(), pick_degree());
      end else begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) add_item(MODE_NBR, pick_weight(), pick_degree());
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_features.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("checked %0d result beats: %0d nodes finished, %0d dropped by a new header,",
             results_seen, nodes_done, nodes_abandoned);
    $display("%0d stray neighbour beats ignored, with random input gaps and output stalls",
             strays_dropped);
    if (errors == 0 && expected_features.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_features.size());
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nnf_pkg.sv
rtl/core/nnf_datapath.sv
rtl/core/nnf_ctrl.sv
rtl/core/node_neighbourhood_features_core.sv
tb/node_neighbourhood_features_core_tb.sv
